>>> hdl/mcmp_pkg.sv
// Shared types and constants for the MIDI channel message parser.
`default_nettype none

package mcmp_pkg;

   // key tables
   localparam int NUM_KEYS = 88;
   localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int VEL_W    = 7;

   // status byte high nibbles
   localparam logic [3:0] HI_NOTE_OFF = 4'h8;
   localparam logic [3:0] HI_NOTE_ON  = 4'h9;
   localparam logic [3:0] HI_CONTROL  = 4'hB;
   localparam logic [3:0] HI_PROGRAM  = 4'hC;
   localparam logic [3:0] HI_DATA_MAX = 4'h7;

   // controller numbers
   localparam logic [7:0] CTL_SUSTAIN = 8'h40;
   localparam logic [7:0] CTL_RED     = 8'd9;
   localparam logic [7:0] CTL_GREEN   = 8'd14;
   localparam logic [7:0] CTL_BLUE    = 8'd15;

   localparam logic [1:0] COLOR_RED   = 2'd0;
   localparam logic [1:0] COLOR_GREEN = 2'd1;
   localparam logic [1:0] COLOR_BLUE  = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_MIDI_CHANNEL = 2'd0;
   localparam logic [1:0] CSR_LOWEST_NOTE  = 2'd1;
   localparam logic [1:0] CSR_DRAWBAR_MODE = 2'd2;

   localparam logic [3:0] RST_MIDI_CHANNEL = 4'd0;
   localparam logic [6:0] RST_LOWEST_NOTE  = 7'd21;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_NOTE_ON    = 3'd1,
      EV_NOTE_OFF   = 3'd2,
      EV_PROGRAM    = 3'd3,
      EV_CONTROL    = 3'd4,
      EV_TABLE_READ = 3'd5
   } event_type;

   typedef enum logic [3:0] {
      PS_STATUS   = 4'd0,
      PS_NOTE_ON  = 4'd1,
      PS_VEL_ON   = 4'd2,
      PS_NOTE_OFF = 4'd3,
      PS_VEL_OFF  = 4'd4,
      PS_PROGRAM  = 4'd5,
      PS_CTL_NUM  = 4'd6,
      PS_CTL_VAL  = 4'd7,
      PS_SKIP     = 4'd8
   } parse_state_type;

   typedef struct packed {
      logic [3:0] midi_channel;
      logic [6:0] lowest_note;
      logic       drawbar_mode;
   } cfg_type;

   typedef struct packed {
      event_type  event_res;
      logic [6:0] key;
      logic [6:0] velocity;
      logic [6:0] program_res;
      logic       color_valid;
      logic [1:0] color_channel;
      logic [7:0] color_level;
      logic [6:0] sustain;
      logic [15:0] error_count;
   } parse_res_type;

   // table update from one parsed byte
   typedef struct packed {
      logic             note_on;
      logic             note_off;
      logic [KEY_W-1:0] key;
      logic [VEL_W-1:0] velocity;
   } tbl_wr_type;

endpackage

`default_nettype wire

>>> hdl/midi_channel_message_parser.sv
// Top level of the MIDI channel message parser: csr, pipeline and output register.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------------------
//  req     | in        | req_tvalid/tready    | tdata: rx_byte, read_key; tuser: action, rx_error
//  rsp     | out       | rsp_tvalid/tready    | tdata: key .. read_release; tuser: event, color_valid
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data (always ready)
//
// One transaction per cycle sustained while rsp_tready stays high; every request
// gives exactly one response. The key table RAMs have a registered read, so a
// request is held in stage 1 and then moves to the output register.
// Reset (synchronous, active high) clears parse state, counters, csr and table
// valid bits at once; no clearing pass, the block is ready the cycle after.
// With rsp stalled, stage 1 and the output register hold two transactions before
// req_tready drops.
`default_nettype none

module midi_channel_message_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [7:0] rx_byte, [14:8] read_key, [15] zero
   input  wire logic [1:0]  req_tuser,  // [0] action, [1] rx_error
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [6:0] key, [13:7] velocity, [20:14] program_res, [22:21] color_channel,
   // [30:23] color_level, [37:31] sustain, [53:38] error_count,
   // [60:54] read_velocity, [67:61] read_release, [71:68] zero
   output logic [71:0]      rsp_tdata,
   output logic [3:0]       rsp_tuser,  // [2:0] event_res, [3] color_valid
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_data
);

   mcmp_pkg::cfg_type       cfg_ff;
   mcmp_pkg::parse_res_type parse_res;
   mcmp_pkg::parse_res_type s1_res_ff;
   mcmp_pkg::tbl_wr_type    tbl_wr;
   logic                    req_accept;
   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic                    s1_adv;
   logic                    rsp_tvalid_ff;
   logic                    rsp_tvalid_in;
   logic [71:0]             rsp_tdata_ff;
   logic [3:0]              rsp_tuser_ff;
   logic [6:0]              rd_velocity;
   logic [6:0]              rd_release;
   logic [6:0]              out_rd_velocity;
   logic [6:0]              out_rd_release;

   // ---------------------------------------------------------------- csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.midi_channel <= mcmp_pkg::RST_MIDI_CHANNEL;
         cfg_ff.lowest_note  <= mcmp_pkg::RST_LOWEST_NOTE;
         cfg_ff.drawbar_mode <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mcmp_pkg::CSR_MIDI_CHANNEL: cfg_ff.midi_channel <= csr_data[3:0];
            mcmp_pkg::CSR_LOWEST_NOTE:  cfg_ff.lowest_note  <= csr_data;
            mcmp_pkg::CSR_DRAWBAR_MODE: cfg_ff.drawbar_mode <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // stage 1 moves on when the output register is free or being drained
   assign s1_adv        = s1_valid_ff && (!rsp_tvalid_ff || rsp_tready);
   assign req_tready    = !s1_valid_ff || s1_adv;
   assign req_accept    = req_tvalid && req_tready;
   assign s1_valid_in   = req_accept || (s1_valid_ff && !s1_adv);
   assign rsp_tvalid_in = s1_adv || (rsp_tvalid_ff && !rsp_tready);

   // ---------------------------------------------------------------- parse
   mcmp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step_en (req_accept),
      .action  (req_tuser[0]),
      .rx_byte (req_tdata[7:0]),
      .rx_error(req_tuser[1]),
      .res     (parse_res),
      .tbl_wr  (tbl_wr)
   );

   // Table reads and writes never come from the same transaction, and a read
   // issued after a write sees it, so no forwarding path is needed.
   // RAM read data holds until the next read, which only issues when stage 1
   // has moved on.
   mcmp_key_tables u_tables (
      .clock      (clock),
      .reset      (reset),
      .wr         (tbl_wr),
      .rd_en      (req_accept && req_tuser[0]),
      .rd_key     (req_tdata[14:8]),
      .rd_velocity(rd_velocity),
      .rd_release (rd_release)
   );

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_res_ff <= parse_res;
      end
   end

   // ---------------------------------------------------------------- output register
   assign out_rd_velocity =
      (s1_res_ff.event_res == mcmp_pkg::EV_TABLE_READ) ? rd_velocity : '0;
   assign out_rd_release =
      (s1_res_ff.event_res == mcmp_pkg::EV_TABLE_READ) ? rd_release : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_tdata_ff <= {4'b0000, out_rd_release, out_rd_velocity,
                          s1_res_ff.error_count, s1_res_ff.sustain,
                          s1_res_ff.color_level, s1_res_ff.color_channel,
                          s1_res_ff.program_res, s1_res_ff.velocity, s1_res_ff.key};
         rsp_tuser_ff <= {s1_res_ff.color_valid, s1_res_ff.event_res};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // ---------------------------------------------------------------- assertions
   // a stalled stage 1 transaction is never dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("stage 1 transaction lost while stalled");

   // only table reads carry table data
   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[2:0] != mcmp_pkg::EV_TABLE_READ)) |->
      (rsp_tdata[67:54] == 14'd0))
      else $error("table read data on a non-read response");

   // colour levels only come from a control change
   a_color_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[3]) |-> (rsp_tuser[2:0] == mcmp_pkg::EV_CONTROL))
      else $error("colour level outside a control event");

   // note events only for mapped keys
   a_note_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tuser[2:0] == mcmp_pkg::EV_NOTE_ON) ||
                      (rsp_tuser[2:0] == mcmp_pkg::EV_NOTE_OFF))) |->
      ({1'b0, rsp_tdata[6:0]} < 8'(mcmp_pkg::NUM_KEYS)))
      else $error("note event on unmapped key");

endmodule

`default_nettype wire

>>> hdl/mcmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mcmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/mcmp_key_tables.sv
// On-velocity and release-velocity key tables with per-key valid bits.
`default_nettype none

module mcmp_key_tables (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mcmp_pkg::tbl_wr_type    wr,
   input  wire logic                    rd_en,
   input  wire logic [6:0]              rd_key,
   output logic [mcmp_pkg::VEL_W-1:0]   rd_velocity,
   output logic [mcmp_pkg::VEL_W-1:0]   rd_release
);

   logic [mcmp_pkg::NUM_KEYS-1:0] on_vld_ff;
   logic [mcmp_pkg::NUM_KEYS-1:0] on_vld_in;
   logic [mcmp_pkg::NUM_KEYS-1:0] rel_vld_ff;
   logic [mcmp_pkg::NUM_KEYS-1:0] rel_vld_in;
   logic [mcmp_pkg::KEY_W-1:0]    rd_addr;
   logic                          rd_mapped;
   logic                          on_hit_ff;
   logic                          rel_hit_ff;
   logic [mcmp_pkg::VEL_W-1:0]    on_data;
   logic [mcmp_pkg::VEL_W-1:0]    rel_data;

   assign rd_addr   = rd_key[mcmp_pkg::KEY_W-1:0];
   assign rd_mapped = {1'b0, rd_key} < 8'(mcmp_pkg::NUM_KEYS);

   // note-off zeroes the on entry by clearing its valid bit, no RAM write
   always_comb begin
      on_vld_in  = on_vld_ff;
      rel_vld_in = rel_vld_ff;
      if (wr.note_on) begin
         on_vld_in[wr.key] = 1'b1;
      end
      if (wr.note_off) begin
         on_vld_in[wr.key]  = 1'b0;
         rel_vld_in[wr.key] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_vld_ff  <= '0;
         rel_vld_ff <= '0;
         on_hit_ff  <= 1'b0;
         rel_hit_ff <= 1'b0;
      end else begin
         on_vld_ff  <= on_vld_in;
         rel_vld_ff <= rel_vld_in;
         if (rd_en) begin
            on_hit_ff  <= rd_mapped && on_vld_ff[rd_addr];
            rel_hit_ff <= rd_mapped && rel_vld_ff[rd_addr];
         end
      end
   end

   mcmp_ram #(
      .WIDTH(mcmp_pkg::VEL_W),
      .DEPTH(mcmp_pkg::NUM_KEYS)
   ) u_on_ram (
      .clock  (clock),
      .wr_en  (wr.note_on),
      .wr_addr(wr.key),
      .wr_data(wr.velocity),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(on_data)
   );

   mcmp_ram #(
      .WIDTH(mcmp_pkg::VEL_W),
      .DEPTH(mcmp_pkg::NUM_KEYS)
   ) u_rel_ram (
      .clock  (clock),
      .wr_en  (wr.note_off),
      .wr_addr(wr.key),
      .wr_data(wr.velocity),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rel_data)
   );

   assign rd_velocity = on_hit_ff  ? on_data  : '0;
   assign rd_release  = rel_hit_ff ? rel_data : '0;

endmodule

`default_nettype wire

>>> hdl/mcmp_parser.sv
// Byte-level MIDI parse state machine, sustain level and error counter.
`default_nettype none

module mcmp_parser (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mcmp_pkg::cfg_type       cfg,
   input  wire logic                    step_en,
   input  wire logic                    action,
   input  wire logic [7:0]              rx_byte,
   input  wire logic                    rx_error,
   output mcmp_pkg::parse_res_type      res,
   output mcmp_pkg::tbl_wr_type         tbl_wr
);

   mcmp_pkg::parse_state_type state_ff;
   mcmp_pkg::parse_state_type state_in;
   mcmp_pkg::parse_state_type st_eff;
   logic [7:0]  pending_ff;
   logic [7:0]  pending_in;
   logic [6:0]  sustain_ff;
   logic [6:0]  sustain_in;
   logic [15:0] errcnt_ff;
   logic [15:0] errcnt_in;
   logic [3:0]  hi;
   logic [3:0]  lo;
   logic        byte_step;
   logic        key_mapped;

   assign hi         = rx_byte[7:4];
   assign lo         = rx_byte[3:0];
   assign byte_step  = step_en && !action;
   assign key_mapped = pending_ff < 8'(mcmp_pkg::NUM_KEYS);

   // error forces skip, any status byte restarts
   always_comb begin
      if (rx_error) begin
         st_eff = mcmp_pkg::PS_SKIP;
      end else if (hi > mcmp_pkg::HI_DATA_MAX) begin
         st_eff = mcmp_pkg::PS_STATUS;
      end else begin
         st_eff = state_ff;
      end
   end

   // next state
   always_comb begin
      state_in = st_eff;
      case (st_eff)
         mcmp_pkg::PS_STATUS: begin
            if (lo != cfg.midi_channel) begin
               state_in = mcmp_pkg::PS_SKIP;
            end else begin
               case (hi)
                  mcmp_pkg::HI_NOTE_ON:  state_in = mcmp_pkg::PS_NOTE_ON;
                  mcmp_pkg::HI_NOTE_OFF: state_in = mcmp_pkg::PS_NOTE_OFF;
                  mcmp_pkg::HI_PROGRAM:  state_in = mcmp_pkg::PS_PROGRAM;
                  mcmp_pkg::HI_CONTROL:  state_in = mcmp_pkg::PS_CTL_NUM;
                  default:               state_in = mcmp_pkg::PS_SKIP;
               endcase
            end
         end
         mcmp_pkg::PS_NOTE_ON:  state_in = mcmp_pkg::PS_VEL_ON;
         mcmp_pkg::PS_NOTE_OFF: state_in = mcmp_pkg::PS_VEL_OFF;
         mcmp_pkg::PS_VEL_ON,
         mcmp_pkg::PS_VEL_OFF: begin
            // unmapped key: stay and drop data bytes
            state_in = key_mapped ? mcmp_pkg::PS_SKIP : st_eff;
         end
         mcmp_pkg::PS_PROGRAM:  state_in = mcmp_pkg::PS_SKIP;
         mcmp_pkg::PS_CTL_NUM:  state_in = mcmp_pkg::PS_CTL_VAL;
         mcmp_pkg::PS_CTL_VAL:  state_in = mcmp_pkg::PS_SKIP;
         default:               state_in = st_eff;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      pending_in        = pending_ff;
      sustain_in        = sustain_ff;
      errcnt_in         = rx_error ? errcnt_ff + 16'd1 : errcnt_ff;
      res               = '0;
      res.event_res     = mcmp_pkg::EV_NONE;
      tbl_wr            = '0;
      tbl_wr.key        = pending_ff[mcmp_pkg::KEY_W-1:0];
      tbl_wr.velocity   = rx_byte[6:0];
      case (st_eff)
         mcmp_pkg::PS_NOTE_ON,
         mcmp_pkg::PS_NOTE_OFF: begin
            pending_in = rx_byte - {1'b0, cfg.lowest_note};
         end
         mcmp_pkg::PS_VEL_ON: begin
            if (key_mapped) begin
               res.event_res  = mcmp_pkg::EV_NOTE_ON;
               res.key        = pending_ff[6:0];
               res.velocity   = rx_byte[6:0];
               tbl_wr.note_on = byte_step;
            end
         end
         mcmp_pkg::PS_VEL_OFF: begin
            if (key_mapped) begin
               res.event_res   = mcmp_pkg::EV_NOTE_OFF;
               res.key         = pending_ff[6:0];
               res.velocity    = rx_byte[6:0];
               tbl_wr.note_off = byte_step;
            end
         end
         mcmp_pkg::PS_PROGRAM: begin
            res.event_res   = mcmp_pkg::EV_PROGRAM;
            res.program_res = rx_byte[6:0];
         end
         mcmp_pkg::PS_CTL_NUM: begin
            pending_in = rx_byte;
         end
         mcmp_pkg::PS_CTL_VAL: begin
            res.event_res = mcmp_pkg::EV_CONTROL;
            if (pending_ff == mcmp_pkg::CTL_SUSTAIN) begin
               sustain_in = rx_byte[6:0];
            end else if (cfg.drawbar_mode && (pending_ff inside
                  {mcmp_pkg::CTL_RED, mcmp_pkg::CTL_GREEN, mcmp_pkg::CTL_BLUE})) begin
               res.color_valid = 1'b1;
               res.color_level = {rx_byte[6:0], 1'b0};
               if (pending_ff == mcmp_pkg::CTL_RED) begin
                  res.color_channel = mcmp_pkg::COLOR_RED;
               end else if (pending_ff == mcmp_pkg::CTL_GREEN) begin
                  res.color_channel = mcmp_pkg::COLOR_GREEN;
               end else begin
                  res.color_channel = mcmp_pkg::COLOR_BLUE;
               end
            end
         end
         default: begin
         end
      endcase
      if (action) begin
         // table read: report only, no state change
         res            = '0;
         res.event_res  = mcmp_pkg::EV_TABLE_READ;
         sustain_in     = sustain_ff;
         errcnt_in      = errcnt_ff;
      end
      res.sustain     = sustain_in;
      res.error_count = errcnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mcmp_pkg::PS_STATUS;
         pending_ff <= '0;
         sustain_ff <= '0;
         errcnt_ff  <= '0;
      end else if (byte_step) begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         sustain_ff <= sustain_in;
         errcnt_ff  <= errcnt_in;
      end
   end

endmodule

`default_nettype wire
